// ===== hw/rtl/aes_pkg.sv =====
`default_nettype none
package aes_pkg;

    typedef struct packed {
        logic [63:0] data_high;
        logic [63:0] data_low;
        logic        chain_start;
        logic [4:0]  valid_bytes;
    } t_in_item;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
    } t_out_item;

    localparam logic [2:0] REG_KEY_HIGH = 3'd0;
    localparam logic [2:0] REG_KEY_LOW  = 3'd1;
    localparam logic [2:0] REG_IV_HIGH  = 3'd2;
    localparam logic [2:0] REG_IV_LOW   = 3'd3;
    localparam logic [2:0] REG_DECRYPT  = 3'd4;
    localparam logic [2:0] REG_CHAIN    = 3'd5;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [7:0] GF_POLY  = 8'h1b;
    localparam int         NUM_RKEYS = 44;

    localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xt(input logic [7:0] a);
        xt = {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] v);
        logic [7:0] r;
        r = 8'h00;
        for (int i = 0; i < 256; i++) begin
            if (SBOX[i] == v) begin
                r = 8'(i);
            end
        end
        inv_sbox = r;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/aes_keysched.sv =====
`default_nettype none
module aes_keysched (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [127:0] i_key,
    input  wire logic [5:0]   i_rd_addr,
    output logic [31:0]       o_rd_data,
    output logic              o_busy
);
    import aes_pkg::*;

    logic [31:0] r_mem [NUM_RKEYS];
    logic [127:0] r_win;
    logic [5:0] r_idx;
    logic [7:0] r_rc;
    logic r_busy;
    logic [31:0] r_rd_data;
    logic [31:0] n_t;
    logic [31:0] n_rot;
    logic [31:0] n_word;

    always_comb begin
        n_rot = {r_win[23:0], r_win[31:24]};
        if (r_idx[1:0] == 2'd0) begin
            n_t = {SBOX[n_rot[31:24]] ^ r_rc, SBOX[n_rot[23:16]],
                   SBOX[n_rot[15:8]], SBOX[n_rot[7:0]]};
        end else begin
            n_t = r_win[31:0];
        end
        n_word = r_win[127:96] ^ n_t;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_idx  <= 6'd0;
            r_rc   <= 8'h01;
            r_win  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_idx  <= 6'd0;
            r_rc   <= 8'h01;
            r_win  <= i_key;
        end else if (r_busy) begin
            if (r_idx < 6'd4) begin
                r_mem[r_idx[5:0]] <= r_win[127 - 32 * r_idx[1:0] -: 32];
                if (r_idx == 6'd3) begin
                    r_idx <= 6'd4;
                end else begin
                    r_idx <= r_idx + 6'd1;
                end
            end else begin
                r_mem[r_idx] <= n_word;
                r_win <= {r_win[95:0], n_word};
                if (r_idx[1:0] == 2'd0) begin
                    r_rc <= xt(r_rc);
                end
                if (r_idx == 6'(NUM_RKEYS - 1)) begin
                    r_busy <= 1'b0;
                end
                r_idx <= r_idx + 6'd1;
            end
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
    assign o_busy = r_busy;
endmodule
`default_nettype wire

// ===== hw/rtl/aes128_block_cipher_cbc.sv =====
`default_nettype none
// Channel | Signals                          | Direction
// in      | i_in_valid, o_in_ready, i_in     | item into the block
// out     | o_out_valid, i_out_ready, o_out  | result out of the block
// cfg     | i_cfg_we, i_cfg_idx, i_cfg_data  | register writes
// A result follows its input transfer through a load step, eleven rounds of four columns
// on the shared column unit, and the output register, once the previous result has left it.
// A new block is accepted only after the previous result is written to the output register.
// The unit processes one 32-bit column a cycle, reading one round-key word.
// After reset and after a key write the schedule is rebuilt before a block is accepted.
// A finished result is held in the output register until its transfer.
// Reset is synchronous and active low.
module aes128_block_cipher_cbc (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire aes_pkg::t_in_item  i_in,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output aes_pkg::t_out_item      o_out,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_idx,
    input  wire logic [63:0]        i_cfg_data
);
    import aes_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_LOAD, S_RUN, S_DONE} t_state;

    t_state r_state;
    logic [63:0] r_key_h, r_key_l, r_iv_h, r_iv_l;
    logic r_dec, r_cbc, r_kstart;
    logic [127:0] r_chain, r_st, r_cin, r_acc;
    logic [3:0] r_rnd;
    logic [1:0] r_col;
    logic [127:0] r_out;
    logic [127:0] r_work;
    logic r_out_valid;
    logic [5:0] rd_addr;
    logic [31:0] rk;
    logic ks_busy;
    logic [127:0] n_pre;
    logic [127:0] n_shift;
    logic [31:0] n_colin, n_mixed, n_res;
    logic [7:0] m0, m1, m2, m3;

    aes_keysched u_ks (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_kstart),
        .i_key({r_key_h, r_key_l}), .i_rd_addr(rd_addr),
        .o_rd_data(rk), .o_busy(ks_busy)
    );

    function automatic logic [7:0] gm(input logic [7:0] a, input logic [3:0] b);
        logic [7:0] a2, a4, a8, r;
        a2 = xt(a); a4 = xt(a2); a8 = xt(a4);
        r = (b[0] ? a : 8'h00) ^ (b[1] ? a2 : 8'h00) ^ (b[2] ? a4 : 8'h00)
            ^ (b[3] ? a8 : 8'h00);
        gm = r;
    endfunction

    // Round key word for the column being processed in the next cycle.
    logic [1:0] n_col;
    logic [3:0] n_rnd;
    always_comb begin
        n_col = r_col + 2'd1;
        n_rnd = (r_col == 2'd3) ? r_rnd + 4'd1 : r_rnd;
        if (r_state != S_RUN || (r_col == 2'd3 && r_rnd == 4'd10)) begin
            n_col = 2'd0;
            n_rnd = 4'd0;
        end
        rd_addr = r_dec ? {4'd10 - n_rnd, n_col} : {n_rnd, n_col};
    end

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                if (r_dec) begin
                    n_shift[127 - 8 * (4 * c + r) -: 8] =
                        inv_sbox(r_st[127 - 8 * (4 * ((c + 4 - r) % 4) + r) -: 8]);
                end else begin
                    n_shift[127 - 8 * (4 * c + r) -: 8] =
                        SBOX[r_st[127 - 8 * (4 * ((c + r) % 4) + r) -: 8]];
                end
            end
        end
        n_pre = (r_rnd == 4'd0) ? r_st : n_shift;
        n_colin = n_pre[127 - 32 * r_col -: 32];
        m0 = n_colin[31:24]; m1 = n_colin[23:16]; m2 = n_colin[15:8]; m3 = n_colin[7:0];
        if (!r_dec) begin
            n_mixed = {xt(m0) ^ xt(m1) ^ m1 ^ m2 ^ m3,
                       m0 ^ xt(m1) ^ xt(m2) ^ m2 ^ m3,
                       m0 ^ m1 ^ xt(m2) ^ xt(m3) ^ m3,
                       xt(m0) ^ m0 ^ m1 ^ m2 ^ xt(m3)};
            n_res = ((r_rnd == 4'd0 || r_rnd == 4'd10) ? n_colin : n_mixed) ^ rk;
        end else begin
            n_mixed = n_colin ^ rk;
            m0 = n_mixed[31:24]; m1 = n_mixed[23:16];
            m2 = n_mixed[15:8];  m3 = n_mixed[7:0];
            if (r_rnd == 4'd0 || r_rnd == 4'd10) begin
                n_res = n_mixed;
            end else begin
                n_res = {gm(m0, 4'd14) ^ gm(m1, 4'd11) ^ gm(m2, 4'd13) ^ gm(m3, 4'd9),
                         gm(m0, 4'd9) ^ gm(m1, 4'd14) ^ gm(m2, 4'd11) ^ gm(m3, 4'd13),
                         gm(m0, 4'd13) ^ gm(m1, 4'd9) ^ gm(m2, 4'd14) ^ gm(m3, 4'd11),
                         gm(m0, 4'd11) ^ gm(m1, 4'd13) ^ gm(m2, 4'd9) ^ gm(m3, 4'd14)};
            end
        end
    end

    logic [127:0] n_in;
    always_comb begin
        n_in = {i_in.data_high, i_in.data_low};
        for (int i = 0; i < 16; i++) begin
            if (5'(i) >= i_in.valid_bytes) begin
                n_in[127 - 8 * i -: 8] = PAD_BYTE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_key_h <= '0; r_key_l <= '0; r_iv_h <= '0; r_iv_l <= '0;
            r_dec <= 1'b0; r_cbc <= 1'b1; r_kstart <= 1'b0;
            r_chain <= '0;
            r_out_valid <= 1'b0;
            r_rnd <= 4'd0; r_col <= 2'd0;
        end else begin
            r_kstart <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_KEY_HIGH: begin r_key_h <= i_cfg_data; r_kstart <= 1'b1; end
                    REG_KEY_LOW:  begin r_key_l <= i_cfg_data; r_kstart <= 1'b1; end
                    REG_IV_HIGH:  r_iv_h <= i_cfg_data;
                    REG_IV_LOW:   r_iv_l <= i_cfg_data;
                    REG_DECRYPT:  r_dec <= i_cfg_data[0];
                    REG_CHAIN:    r_cbc <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid && o_in_ready) begin
                        r_cin <= i_in.chain_start ? {r_iv_h, r_iv_l} : r_chain;
                        if (i_in.chain_start) begin
                            r_chain <= {r_iv_h, r_iv_l};
                        end
                        r_acc <= {i_in.data_high, i_in.data_low};
                        r_st <= r_dec ? {i_in.data_high, i_in.data_low} : n_in;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    if (!r_dec && r_cbc) begin
                        r_st <= r_st ^ r_cin;
                    end
                    r_rnd <= 4'd0;
                    r_col <= 2'd0;
                    r_state <= S_RUN;
                end
                S_RUN: begin
                    if (r_col == 2'd3) begin
                        r_st <= {r_work[127:32], n_res};
                    end
                    r_col <= r_col + 2'd1;
                    if (r_col == 2'd3) begin
                        r_rnd <= r_rnd + 4'd1;
                        if (r_rnd == 4'd10) begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    if (!r_out_valid) begin
                        if (r_dec) begin
                            r_out <= r_cbc ? r_st ^ r_cin : r_st;
                            if (r_cbc) r_chain <= r_acc;
                        end else begin
                            r_out <= r_st;
                            if (r_cbc) r_chain <= r_st;
                        end
                        r_out_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // The round state stays whole during a round; finished columns collect here.
    always_ff @(posedge i_clk) begin
        if (r_state == S_RUN) begin
            r_work[127 - 32 * r_col -: 32] <= n_res;
        end
    end

    assign o_in_ready = (r_state == S_IDLE) && !ks_busy && !r_kstart;
    assign o_out_valid = r_out_valid;
    assign o_out.result_high = r_out[127:64];
    assign o_out.result_low = r_out[63:0];
endmodule
`default_nettype wire

// ===== hw/rtl/aes_checker.sv =====
`default_nettype none
module aes_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic o_in_ready,
    input wire logic o_out_valid,
    input wire logic i_out_ready,
    input wire logic i_cfg_we
);
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready) else $error("ready after transfer");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid) else $error("result dropped");
    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !$rose(o_out_valid)) else $error("result too early");
    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid) else $error("valid after reset");
    a_cfg_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |-> !o_out_valid) else $error("register write with a result pending");
endmodule

bind aes128_block_cipher_cbc aes_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
    .o_in_ready(o_in_ready), .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready), .i_cfg_we(i_cfg_we)
);
`default_nettype wire

// ===== sim/tb_aes128_block_cipher_cbc.sv =====
`timescale 1ns / 1ps
module tb_aes128_block_cipher_cbc;
    import aes_pkg::*;

    typedef enum int {
        SET_KEEP, SET_ZERO_ECB_ENC, SET_FIPS_ECB_ENC, SET_FIPS_ECB_DEC,
        SET_ONES_CBC_ENC, SET_ONES_CBC_DEC
    } t_setting;

    typedef struct {
        t_setting    setting;
        logic [63:0] hi;
        logic [63:0] lo;
        logic        start;
        logic [4:0]  nbytes;
        logic        pinned;
        logic [127:0] want;
    } t_row;

    localparam logic [127:0] FIPS_KEY = 128'h000102030405060708090a0b0c0d0e0f;
    localparam logic [127:0] FIPS_PT  = 128'h00112233445566778899aabbccddeeff;
    localparam logic [127:0] FIPS_CT  = 128'h69c4e0d86a7b0430d8cdb78070b4c55a;
    localparam logic [63:0]  ONES     = 64'hffff_ffff_ffff_ffff;
    localparam int           NUM_PHASES = 15;
    localparam int           PHASE_BLOCKS = 130;
    localparam int           HOLD_CYCLES = 400;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [63:0] i_cfg_data = '0;

    aes128_block_cipher_cbc dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out(o_out),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    logic [63:0] mdl_key_hi, mdl_key_lo, mdl_iv_hi, mdl_iv_lo;
    logic        mdl_decrypt, mdl_chain;
    logic [127:0] mdl_chain_value;
    logic [31:0] sched [44];
    logic [7:0]  inv_tab [256];

    t_out_item   expected_blocks [$];
    int          mismatches = 0;
    int          blocks_checked = 0;
    int          blocks_sent = 0;
    logic        pin_en = 1'b0;
    logic [127:0] pin_val = '0;
    logic        hold_req = 1'b0;
    logic        no_idle = 1'b0;

    function automatic logic [7:0] dbl(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] r;
        r = 8'h00;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) begin
                r ^= a;
            end
            a = dbl(a);
        end
        return r;
    endfunction

    function automatic void build_schedule();
        logic [31:0] t;
        logic [7:0]  rc;
        rc = 8'h01;
        sched[0] = mdl_key_hi[63:32];
        sched[1] = mdl_key_hi[31:0];
        sched[2] = mdl_key_lo[63:32];
        sched[3] = mdl_key_lo[31:0];
        for (int i = 4; i < 44; i++) begin
            t = sched[i-1];
            if (i % 4 == 0) begin
                t = {SBOX[t[23:16]], SBOX[t[15:8]], SBOX[t[7:0]], SBOX[t[31:24]]}
                    ^ {rc, 24'h0};
                rc = dbl(rc);
            end
            sched[i] = sched[i-4] ^ t;
        end
    endfunction

    function automatic logic [127:0] add_round_key(input logic [127:0] s, input int rnd);
        return s ^ {sched[4*rnd], sched[4*rnd+1], sched[4*rnd+2], sched[4*rnd+3]};
    endfunction

    function automatic logic [127:0] sub_shift(input logic [127:0] s, input logic inv);
        logic [127:0] t;
        int src;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                src = inv ? 4*((c + 4 - r) % 4) + r : 4*((c + r) % 4) + r;
                t[127-8*(4*c+r) -: 8] = inv ? inv_tab[s[127-8*src -: 8]]
                                            : SBOX[s[127-8*src -: 8]];
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic inv);
        logic [7:0] m [4];
        logic [7:0] acc;
        logic [127:0] t;
        if (inv) begin
            m = '{8'd14, 8'd11, 8'd13, 8'd9};
        end else begin
            m = '{8'd2, 8'd3, 8'd1, 8'd1};
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                acc = 8'h00;
                for (int k = 0; k < 4; k++) begin
                    acc ^= gf_mul(s[127-8*(4*c+k) -: 8], m[(k + 4 - r) % 4]);
                end
                t[127-8*(4*c+r) -: 8] = acc;
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] cipher_block(input logic [127:0] s);
        s = add_round_key(s, 0);
        for (int rnd = 1; rnd < 10; rnd++) begin
            s = add_round_key(mix_columns(sub_shift(s, 1'b0), 1'b0), rnd);
        end
        return add_round_key(sub_shift(s, 1'b0), 10);
    endfunction

    function automatic logic [127:0] inv_cipher_block(input logic [127:0] s);
        s = add_round_key(s, 10);
        for (int rnd = 9; rnd > 0; rnd--) begin
            s = mix_columns(add_round_key(sub_shift(s, 1'b1), rnd), 1'b1);
        end
        return add_round_key(sub_shift(s, 1'b1), 0);
    endfunction

    function automatic t_out_item predict_block(input t_in_item it);
        logic [127:0] s;
        logic [127:0] r;
        if (it.chain_start) begin
            mdl_chain_value = {mdl_iv_hi, mdl_iv_lo};
        end
        s = {it.data_high, it.data_low};
        if (!mdl_decrypt) begin
            for (int i = 0; i < 16; i++) begin
                if (i >= it.valid_bytes) begin
                    s[127-8*i -: 8] = PAD_BYTE;
                end
            end
            if (mdl_chain) begin
                s ^= mdl_chain_value;
            end
            r = cipher_block(s);
            if (mdl_chain) begin
                mdl_chain_value = r;
            end
        end else begin
            r = inv_cipher_block(s);
            if (mdl_chain) begin
                r ^= mdl_chain_value;
                mdl_chain_value = s;
            end
        end
        return t_out_item'(r);
    endfunction

    function automatic void model_write(input logic [2:0] idx, input logic [63:0] v);
        case (idx)
            REG_KEY_HIGH: begin mdl_key_hi = v; build_schedule(); end
            REG_KEY_LOW:  begin mdl_key_lo = v; build_schedule(); end
            REG_IV_HIGH:  mdl_iv_hi = v;
            REG_IV_LOW:   mdl_iv_lo = v;
            REG_DECRYPT:  mdl_decrypt = v[0];
            REG_CHAIN:    mdl_chain = v[0];
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item pred;
        if (!i_rst_n) begin
            mdl_key_hi = '0;
            mdl_key_lo = '0;
            mdl_iv_hi = '0;
            mdl_iv_lo = '0;
            mdl_decrypt = 1'b0;
            mdl_chain = 1'b1;
            mdl_chain_value = '0;
            build_schedule();
        end else begin
            if (i_cfg_we) begin
                model_write(i_cfg_idx, i_cfg_data);
            end
            if (i_in_valid && o_in_ready) begin
                pred = predict_block(i_in);
                expected_blocks.push_back(pin_en ? t_out_item'(pin_val) : pred);
            end
            if (o_out_valid && i_out_ready) begin
                blocks_checked++;
                if (expected_blocks.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected output block %h_%h",
                                 o_out.result_high, o_out.result_low);
                    end
                end else begin
                    want = expected_blocks.pop_front();
                    if (o_out.result_high !== want.result_high
                        || o_out.result_low !== want.result_low) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("block mismatch: expected %h_%h actual %h_%h",
                                     want.result_high, want.result_low,
                                     o_out.result_high, o_out.result_low);
                        end
                    end
                end
            end
        end
    end

    initial begin
        int hold_count;
        hold_count = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req && hold_count == 0) begin
                hold_count = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_count > 0) begin
                hold_count--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= no_idle || ($urandom_range(0, 99) >= 22);
            end
        end
    end

    task automatic cfg_write(input logic [2:0] idx, input logic [63:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_blocks.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (60) @(negedge i_clk);
    endtask

    task automatic write_all(input logic [127:0] key, input logic [127:0] iv,
                             input logic dec, input logic chain);
        wait_drained();
        cfg_write(REG_KEY_HIGH, key[127:64]);
        cfg_write(REG_KEY_LOW, key[63:0]);
        cfg_write(REG_IV_HIGH, iv[127:64]);
        cfg_write(REG_IV_LOW, iv[63:0]);
        cfg_write(REG_DECRYPT, {63'h0, dec});
        cfg_write(REG_CHAIN, {63'h0, chain});
    endtask

    task automatic apply_setting(input t_setting st);
        case (st)
            SET_ZERO_ECB_ENC: write_all('0, '0, 1'b0, 1'b0);
            SET_FIPS_ECB_ENC: write_all(FIPS_KEY, '0, 1'b0, 1'b0);
            SET_FIPS_ECB_DEC: begin
                wait_drained();
                cfg_write(REG_DECRYPT, ONES);
            end
            SET_ONES_CBC_ENC: begin
                write_all({ONES, ONES}, {ONES, ONES}, 1'b0, 1'b1);
                cfg_write(3'd6, ONES);
                cfg_write(3'd7, 64'h0123_4567_89ab_cdef);
            end
            SET_ONES_CBC_DEC: begin
                wait_drained();
                cfg_write(REG_DECRYPT, 64'h1);
                cfg_write(REG_CHAIN, ONES);
            end
            default: ;
        endcase
    endtask

    task automatic send_block(input t_in_item it, input logic pinned,
                              input logic [127:0] want);
        if (!no_idle && $urandom_range(0, 99) < 22) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= it;
        pin_en <= pinned;
        pin_val <= want;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        blocks_sent++;
        @(negedge i_clk);
        pin_en <= 1'b0;
    endtask

    task automatic stop_sending();
        i_in_valid <= 1'b0;
    endtask

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 15))
            0: return '0;
            1: return ONES;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    t_row directed [] = '{
        '{SET_ZERO_ECB_ENC, 64'h0, 64'h0, 1'b0, 5'd16, 1'b1,
          128'h66e94bd4ef8a2c3b884cfa59ca342b2e},
        '{SET_KEEP, ONES, ONES, 1'b0, 5'd16, 1'b0, '0},
        '{SET_KEEP, 64'h0, 64'h0, 1'b1, 5'd0, 1'b0, '0},
        '{SET_KEEP, 64'h0, 64'h0, 1'b0, 5'd1, 1'b0, '0},
        '{SET_KEEP, ONES, ONES, 1'b0, 5'd15, 1'b0, '0},
        '{SET_KEEP, ONES, ONES, 1'b0, 5'd17, 1'b0, '0},
        '{SET_KEEP, 64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0, 5'd31, 1'b0, '0},
        '{SET_FIPS_ECB_ENC, FIPS_PT[127:64], FIPS_PT[63:0], 1'b0, 5'd16, 1'b1, FIPS_CT},
        '{SET_FIPS_ECB_DEC, FIPS_CT[127:64], FIPS_CT[63:0], 1'b0, 5'd0, 1'b1, FIPS_PT},
        '{SET_KEEP, FIPS_CT[127:64], FIPS_CT[63:0], 1'b1, 5'd16, 1'b1, FIPS_PT},
        '{SET_ONES_CBC_ENC, ONES, 64'h0, 1'b1, 5'd16, 1'b0, '0},
        '{SET_KEEP, 64'h0, ONES, 1'b0, 5'd8, 1'b0, '0},
        '{SET_KEEP, 64'h5555aaaa5555aaaa, 64'haaaa5555aaaa5555, 1'b0, 5'd0, 1'b0, '0},
        '{SET_KEEP, ONES, ONES, 1'b1, 5'd16, 1'b0, '0},
        '{SET_ONES_CBC_DEC, ONES, 64'h0, 1'b1, 5'd16, 1'b0, '0},
        '{SET_KEEP, 64'h0, ONES, 1'b0, 5'd3, 1'b0, '0},
        '{SET_KEEP, 64'h0, 64'h0, 1'b0, 5'd16, 1'b0, '0},
        '{SET_KEEP, ONES, ONES, 1'b1, 5'd16, 1'b0, '0}
    };

    initial begin
        t_in_item it;
        logic [127:0] key;
        logic [127:0] iv;
        logic chain;
        for (int i = 0; i < 256; i++) begin
            inv_tab[SBOX[i]] = 8'(i);
        end
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed[n]) begin
            if (directed[n].setting != SET_KEEP) begin
                stop_sending();
                apply_setting(directed[n].setting);
            end
            it.data_high = directed[n].hi;
            it.data_low = directed[n].lo;
            it.chain_start = directed[n].start;
            it.valid_bytes = directed[n].nbytes;
            send_block(it, directed[n].pinned, directed[n].want);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            stop_sending();
            key = (p == 0) ? '0 : (p == 1) ? {ONES, ONES} : {rand_word(), rand_word()};
            iv = (p == 0) ? {ONES, ONES} : (p == 1) ? '0 : {rand_word(), rand_word()};
            chain = (p % 5 != 4);
            write_all(key, iv, p[0], chain);
            no_idle = (p == 6);
            for (int b = 0; b < PHASE_BLOCKS; b++) begin
                if (p == 4 && b == 10) begin
                    hold_req = 1'b1;
                end
                if (p == 9 && b == 60) begin
                    stop_sending();
                    while (expected_blocks.size() != 0) begin
                        @(negedge i_clk);
                    end
                end
                it.data_high = rand_word();
                it.data_low = rand_word();
                it.chain_start = (b == 0) || ($urandom_range(0, 9) == 0);
                it.valid_bytes = ($urandom_range(0, 2) == 0) ? 5'($urandom_range(0, 31))
                                                             : 5'd16;
                send_block(it, 1'b0, '0);
            end
            no_idle = 1'b0;
        end
        stop_sending();

        while (expected_blocks.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (100) @(negedge i_clk);
        $display("Sent %0d blocks, checked %0d results, %0d mismatches.",
                 blocks_sent, blocks_checked, mismatches);
        $display("Covered ECB and CBC, encrypt and decrypt, padding and chain restarts.");
        if (mismatches == 0 && expected_blocks.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
